@@ rtl/pdq_pkg.sv @@
// Shared types and constants for the packet delay queue.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package pdq_pkg;

    // Fixed field widths
    localparam int TAG_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int LAG_W     = 14;
    localparam int PEND_W    = 12;
    localparam int REQ_W     = 2;
    localparam int CAUSE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Lag limits and reset value
    localparam logic [LAG_W-1:0] LAG_MAX   = 14'd15000;
    localparam logic [LAG_W-1:0] LAG_RESET = 14'd50;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ARRIVE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POLL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DRAIN  = 2'd2;

    // Release causes
    localparam logic [CAUSE_W-1:0] CAUSE_DIRECT  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL    = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_OVERDUE = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_FLUSH   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_INBOUND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_OUTBOUND = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic               load;
        logic               push;
        logic               pop;
        logic               emit;
        logic [CAUSE_W-1:0] cause;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             lagged;
        logic             full;
        logic             empty;
        logic             flush_armed;
        logic             overdue;
        logic             out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/pdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/pdq_ctrl.sv @@
// Controller for the packet delay queue: accepts a request, then decides it.
// Depends on pdq_pkg.
`default_nettype none

module pdq_ctrl
    import pdq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    logic               want_emit;
    logic               want_pop;
    logic               want_push;
    logic [CAUSE_W-1:0] want_cause;

    // Decide what the held request does
    always_comb begin
        want_emit  = 1'b0;
        want_pop   = 1'b0;
        want_push  = 1'b0;
        want_cause = CAUSE_DIRECT;
        case (i_status.req)
            REQ_ARRIVE: begin
                if (!i_status.lagged) begin
                    want_emit  = 1'b1;
                    want_cause = CAUSE_DIRECT;
                end else if (i_status.full) begin
                    want_emit  = 1'b1;
                    want_cause = CAUSE_FULL;
                end else begin
                    want_push = 1'b1;
                end
            end
            REQ_POLL: begin
                if (!i_status.empty) begin
                    if (i_status.flush_armed) begin
                        want_emit  = 1'b1;
                        want_pop   = 1'b1;
                        want_cause = CAUSE_FLUSH;
                    end else if (i_status.overdue) begin
                        want_emit  = 1'b1;
                        want_pop   = 1'b1;
                        want_cause = CAUSE_OVERDUE;
                    end
                end
            end
            REQ_DRAIN: begin
                if (!i_status.empty) begin
                    want_emit  = 1'b1;
                    want_pop   = 1'b1;
                    want_cause = CAUSE_FLUSH;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state: wait in EXEC while the output slot is taken
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!want_emit || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.push  = want_push;
                o_cmd.pop   = want_pop && i_status.out_free;
                o_cmd.emit  = want_emit && i_status.out_free;
                o_cmd.cause = want_cause;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pdq_datapath.sv @@
// Datapath for the packet delay queue: stores, pointers, counts, lag registers
// and the result register. Depends on pdq_pkg and pdq_ram.
`default_nettype none

module pdq_datapath
    import pdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048,
    parameter int FLUSH_COUNT = 800
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [TAG_W-1:0]     i_packet_tag,
    input  wire logic                 i_is_outbound,
    input  wire logic [STAMP_W-1:0]   i_now_ms,
    input  wire logic                 i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LAG_W-1:0]     i_cfg_data,
    input  wire logic                 i_out_stall,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic                      o_out_valid,
    output logic [TAG_W-1:0]          o_out_tag,
    output logic [CAUSE_W-1:0]        o_release_cause,
    output logic [PEND_W-1:0]         o_pending_count
);

    localparam int AW         = $clog2(QUEUE_DEPTH);
    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int FLUSH_INIT = (FLUSH_COUNT > QUEUE_DEPTH) ? QUEUE_DEPTH : FLUSH_COUNT;

    localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] FLUSH_LOAD = CW'(FLUSH_INIT);

    // Held request
    logic [REQ_W-1:0]   r_req;
    logic [TAG_W-1:0]   r_tag;
    logic               r_outbound;
    logic [STAMP_W-1:0] r_now;

    // Configuration
    logic [LAG_W-1:0] r_lag_time;
    logic             r_lag_in;
    logic             r_lag_out;

    // Queue control
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_held;
    logic [CW-1:0] r_flush;
    logic [CW-1:0] n_held;

    // Head entry from the stores
    logic [TAG_W-1:0]   head_tag;
    logic [STAMP_W-1:0] head_stamp;
    logic [STAMP_W-1:0] due;

    pdq_ram #(
        .WIDTH(TAG_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_tag),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (head_tag)
    );

    pdq_ram #(
        .WIDTH(STAMP_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_now),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (head_stamp)
    );

    // Deadline of the oldest entry, wrapping at 32 bits
    assign due = head_stamp + STAMP_W'(r_lag_time);

    // Status towards the controller
    always_comb begin
        o_status.req         = r_req;
        o_status.lagged      = r_outbound ? r_lag_out : r_lag_in;
        o_status.full        = (r_held == FULL_COUNT);
        o_status.empty       = (r_held == '0);
        o_status.flush_armed = (r_flush != '0);
        o_status.overdue     = (r_now > due);
        o_status.out_free    = !o_out_valid || !i_out_stall;
    end

    // Count after this step
    always_comb begin
        n_held = r_held;
        if (i_cmd.push) begin
            n_held = r_held + CW'(1);
        end else if (i_cmd.pop) begin
            n_held = r_held - CW'(1);
        end
    end

    // Latch the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req_type;
            r_tag      <= i_packet_tag;
            r_outbound <= i_is_outbound;
            r_now      <= i_now_ms;
        end
    end

    // Configuration writes; lag saturates at its maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_time <= LAG_RESET;
            r_lag_in   <= 1'b1;
            r_lag_out  <= 1'b1;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_LAG_TIME:     r_lag_time <= (i_cfg_data > LAG_MAX) ? LAG_MAX : i_cfg_data;
                CFG_LAG_INBOUND:  r_lag_in   <= i_cfg_data[0];
                CFG_LAG_OUTBOUND: r_lag_out  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Advance pointers, count and flush on push or pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_held   <= '0;
            r_flush  <= '0;
        end else begin
            r_held <= n_held;
            if (i_cmd.push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + AW'(1);
                if (n_held == FULL_COUNT) begin
                    r_flush <= FLUSH_LOAD;
                end
            end else if (i_cmd.pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + AW'(1);
                if (n_held == '0) begin
                    r_flush <= '0;
                end else if (r_flush != '0) begin
                    r_flush <= r_flush - CW'(1);
                end
            end
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_tag       <= i_cmd.pop ? head_tag : r_tag;
            o_release_cause <= i_cmd.cause;
            o_pending_count <= PEND_W'(n_held);
        end
    end

endmodule

`default_nettype wire

@@ rtl/packet_delay_queue_core.sv @@
// Packet delay queue: holds packet descriptors in a timestamped FIFO for a set lag.
// A request is latched into the held-request registers when accepted and decided in the
// exec state; its result is then loaded into the result register, and the decision waits
// in exec while the previous result is still stalled. No new request is taken before that.
// Reset: synchronous active low; queue empty, flush disarmed, lag 50 ms, both directions
// delayed. The stores are not cleared.
`default_nettype none

module packet_delay_queue_core
    import pdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048,
    parameter int FLUSH_COUNT = 800
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [TAG_W-1:0]     i_packet_tag,
    input  wire logic                 i_is_outbound,
    input  wire logic [STAMP_W-1:0]   i_now_ms,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [TAG_W-1:0]          o_out_tag,
    output logic [CAUSE_W-1:0]        o_release_cause,
    output logic [PEND_W-1:0]         o_pending_count,
    // Configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LAG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    pdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pdq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .FLUSH_COUNT(FLUSH_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_packet_tag    (i_packet_tag),
        .i_is_outbound   (i_is_outbound),
        .i_now_ms        (i_now_ms),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_out_tag       (o_out_tag),
        .o_release_cause (o_release_cause),
        .o_pending_count (o_pending_count)
    );

endmodule

`default_nettype wire

@@ rtl/pdq_checker.sv @@
// Port-level checks for the packet delay queue, bound to the top level.
// Depends on pdq_pkg.
`default_nettype none

module pdq_checker
    import pdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [TAG_W-1:0]     o_out_tag,
    input wire logic [CAUSE_W-1:0]   o_release_cause,
    input wire logic [PEND_W-1:0]    o_pending_count
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_tag)
            && $stable(o_release_cause) && $stable(o_pending_count))
        else $error("stalled result beat changed");

    // One request at a time: stall right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous one in progress");

    // A new result only comes out of the decide cycle
    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // A full bypass reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_release_cause == CAUSE_FULL |-> o_pending_count == PEND_W'(QUEUE_DEPTH))
        else $error("full bypass with queue not full");

endmodule

bind packet_delay_queue_core pdq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_pdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_tag       (o_out_tag),
    .o_release_cause (o_release_cause),
    .o_pending_count (o_pending_count)
);

`default_nettype wire
